### rtl/csm_pkg.sv
// Shared constants, types and coefficient function for the color saturate matrix.
`default_nettype none

package csm_pkg;

   localparam int CSM_CHANNEL_BITS = 16;
   localparam int SAT_BITS = 17;
   localparam int COEF_BITS = 17;

   localparam logic [COEF_BITS-1:0] Q16_ONE = 17'd65536;
   localparam logic [15:0] Q16_HALF = 16'd32768;

   // Luma weights in Q16; they add up to exactly one.
   localparam logic [15:0] LUMA_R = 16'd13959;
   localparam logic [15:0] LUMA_G = 16'd46858;
   localparam logic [15:0] LUMA_B = 16'd4719;

   typedef struct packed {
      logic [COEF_BITS-1:0] off_r;
      logic [COEF_BITS-1:0] off_g;
      logic [COEF_BITS-1:0] off_b;
      logic [COEF_BITS-1:0] diag_r;
      logic [COEF_BITS-1:0] diag_g;
      logic [COEF_BITS-1:0] diag_b;
   } coef_type;

   typedef struct packed {
      logic load_mul;
      logic load_sum;
   } stage_ctl_type;

   // Off-diagonal coefficient: weight times (1 - s), rounded to nearest.
   function automatic logic [COEF_BITS-1:0] off_coef(input logic [15:0] weight,
                                                      input logic [COEF_BITS-1:0] inv);
      logic [32:0] prod;
      prod = 33'(weight) * 33'(inv) + 33'(Q16_HALF);
      return prod[32:16];
   endfunction

endpackage

`default_nettype wire

### rtl/color_saturate_matrix_top.sv
// Top level of the color saturate matrix: handshake, pipeline control and channel lanes.
//
// Applies the saturate color matrix to one premultiplied RGBA pixel per beat; alpha
// passes through. The block takes a pixel every cycle while the result side does not
// stall, and presents its result on rsp_tvalid once it has passed an input register,
// a product stage, a sum stage and the output register, each with its own valid bit,
// so a stall on the result side holds the pipeline without loss and the empty stages
// still fill. The matrix is rebuilt in the cycle of a saturation write and applies to
// every pixel accepted after that write.
`default_nettype none

module color_saturate_matrix_top
   import csm_pkg::*;
#(
   parameter int CHANNEL_BITS = CSM_CHANNEL_BITS
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [SAT_BITS-1:0] csr_wdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0 up: red_in, green_in, blue_in, alpha_in, zero padding.
   input  wire logic [((4*CHANNEL_BITS+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // Fields from bit 0 up: red_out, green_out, blue_out, alpha_out, zero padding.
   output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int CB     = CHANNEL_BITS;
   localparam int DATA_W = ((4*CHANNEL_BITS+7)/8)*8;

   coef_type      coef;
   stage_ctl_type ctl;

   logic          v0_ff, v1_ff, v2_ff, vo_ff;
   logic          adv0, adv1, adv2, adv3;
   logic [CB-1:0] r0_ff, g0_ff, b0_ff, a0_ff;
   logic [CB-1:0] a1_ff, a2_ff;
   logic [CB-1:0] ro_ff, go_ff, bo_ff, ao_ff;
   logic [CB-1:0] red_sum, green_sum, blue_sum;

   csm_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      adv3 = !vo_ff || rsp_tready;
      adv2 = !v2_ff || adv3;
      adv1 = !v1_ff || adv2;
      adv0 = !v0_ff || adv1;
      ctl.load_mul = adv1;
      ctl.load_sum = adv2;
   end

   assign req_tready = !reset && adv0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= req_tvalid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) vo_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         r0_ff <= req_tdata[CB-1:0];
         g0_ff <= req_tdata[2*CB-1:CB];
         b0_ff <= req_tdata[3*CB-1:2*CB];
         a0_ff <= req_tdata[4*CB-1:3*CB];
      end
      if (adv1) a1_ff <= a0_ff;
      if (adv2) a2_ff <= a1_ff;
      if (adv3) begin
         ro_ff <= red_sum;
         go_ff <= green_sum;
         bo_ff <= blue_sum;
         ao_ff <= a2_ff;
      end
   end

   csm_mac #(.CHANNEL_BITS(CHANNEL_BITS)) u_mac_red (
      .clock  (clock),
      .ctl    (ctl),
      .c0     (coef.diag_r),
      .c1     (coef.off_g),
      .c2     (coef.off_b),
      .x0     (r0_ff),
      .x1     (g0_ff),
      .x2     (b0_ff),
      .result (red_sum)
   );

   csm_mac #(.CHANNEL_BITS(CHANNEL_BITS)) u_mac_green (
      .clock  (clock),
      .ctl    (ctl),
      .c0     (coef.off_r),
      .c1     (coef.diag_g),
      .c2     (coef.off_b),
      .x0     (r0_ff),
      .x1     (g0_ff),
      .x2     (b0_ff),
      .result (green_sum)
   );

   csm_mac #(.CHANNEL_BITS(CHANNEL_BITS)) u_mac_blue (
      .clock  (clock),
      .ctl    (ctl),
      .c0     (coef.off_r),
      .c1     (coef.off_g),
      .c2     (coef.diag_b),
      .x0     (r0_ff),
      .x1     (g0_ff),
      .x2     (b0_ff),
      .result (blue_sum)
   );

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = DATA_W'({ao_ff, bo_ff, go_ff, ro_ff});

   // Every matrix row must add up to exactly one.
   a_row_sum: assert property (@(posedge clock) disable iff (reset)
      (18'(coef.diag_r) + 18'(coef.off_g) + 18'(coef.off_b) == 18'(Q16_ONE)) &&
      (18'(coef.off_r) + 18'(coef.diag_g) + 18'(coef.off_b) == 18'(Q16_ONE)) &&
      (18'(coef.off_r) + 18'(coef.off_g) + 18'(coef.diag_b) == 18'(Q16_ONE)))
      else $error("saturate matrix row does not sum to one");

   // A result can only appear when the sum stage held a pixel.
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(vo_ff) |-> $past(v2_ff))
      else $error("result beat without a pixel in the sum stage");

   // A pixel held in the input stage keeps its data until the product stage takes it.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (v0_ff && !adv1) |=> ($stable(r0_ff) && $stable(g0_ff) && $stable(b0_ff)
                            && $stable(a0_ff)))
      else $error("stalled input stage lost its pixel");

endmodule

`default_nettype wire

### rtl/csm_coef.sv
// Coefficient register: builds the saturate matrix when the saturation is written.
`default_nettype none

module csm_coef
   import csm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [SAT_BITS-1:0] csr_wdata,
   output coef_type                 coef
);

   coef_type             coef_ff;
   coef_type             coef_in;
   coef_type             coef_new;
   logic [SAT_BITS-1:0]  sat_clamp;
   logic [COEF_BITS-1:0] inv;

   always_comb begin
      // Values above one are treated as one, which gives the identity matrix.
      sat_clamp = (csr_wdata > Q16_ONE) ? Q16_ONE : csr_wdata;
      inv = Q16_ONE - sat_clamp;
      coef_new.off_r = off_coef(LUMA_R, inv);
      coef_new.off_g = off_coef(LUMA_G, inv);
      coef_new.off_b = off_coef(LUMA_B, inv);
      // Diagonals are taken from the row sum so that every row adds up to one.
      coef_new.diag_r = Q16_ONE - coef_new.off_g - coef_new.off_b;
      coef_new.diag_g = Q16_ONE - coef_new.off_r - coef_new.off_b;
      coef_new.diag_b = Q16_ONE - coef_new.off_r - coef_new.off_g;
      coef_in = csr_we ? coef_new : coef_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{off_r: '0, off_g: '0, off_b: '0,
                      diag_r: Q16_ONE, diag_g: Q16_ONE, diag_b: Q16_ONE};
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

### rtl/csm_mac.sv
// One output channel: a registered product stage followed by a registered sum stage.
`default_nettype none

module csm_mac
   import csm_pkg::*;
#(
   parameter int CHANNEL_BITS = CSM_CHANNEL_BITS
)
(
   input  wire logic                    clock,
   input  wire stage_ctl_type           ctl,
   input  wire logic [COEF_BITS-1:0]    c0,
   input  wire logic [COEF_BITS-1:0]    c1,
   input  wire logic [COEF_BITS-1:0]    c2,
   input  wire logic [CHANNEL_BITS-1:0] x0,
   input  wire logic [CHANNEL_BITS-1:0] x1,
   input  wire logic [CHANNEL_BITS-1:0] x2,
   output logic [CHANNEL_BITS-1:0]      result
);

   localparam int FULL_W = CHANNEL_BITS + COEF_BITS;
   // A coefficient of one only meets inputs below full scale, so one bit less suffices.
   localparam int PROD_W = CHANNEL_BITS + 16;

   logic [FULL_W-1:0] full0, full1, full2;
   logic [PROD_W-1:0] prod0_ff, prod1_ff, prod2_ff;
   logic [PROD_W-1:0] sum_ff;
   logic [PROD_W-1:0] sum_in;

   always_comb begin
      full0 = FULL_W'(c0) * FULL_W'(x0);
      full1 = FULL_W'(c1) * FULL_W'(x1);
      full2 = FULL_W'(c2) * FULL_W'(x2);
      // The row sums to one, so the rounded total stays below full scale.
      sum_in = prod0_ff + prod1_ff + prod2_ff + PROD_W'(Q16_HALF);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         prod0_ff <= full0[PROD_W-1:0];
         prod1_ff <= full1[PROD_W-1:0];
         prod2_ff <= full2[PROD_W-1:0];
      end
      if (ctl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign result = sum_ff[PROD_W-1:16];

endmodule

`default_nettype wire

### bench/color_saturate_matrix_top_tb.sv
// Self-checking bench for the color saturate matrix: directed and random pixel streams under several saturations.
`timescale 1ns / 1ps

module color_saturate_matrix_top_tb;
   import csm_pkg::*;

   localparam int CB = CSM_CHANNEL_BITS;
   localparam int PIPE_LATENCY = 4;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [CB-1:0] alpha;
      logic [CB-1:0] blue;
      logic [CB-1:0] green;
      logic [CB-1:0] red;
   } pixel_type;

   localparam logic [4*CB-1:0] DIRECTED_PIXELS [12] = '{
      {16'h0000, 16'h0000, 16'h0000, 16'h0000},
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF},
      {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000},
      {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000},
      {16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
      {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
      {16'h0001, 16'h0001, 16'h0001, 16'h0001},
      {16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF},
      {16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF},
      {16'h1234, 16'h00FF, 16'hFF00, 16'h8001}
   };

   localparam logic [SAT_BITS-1:0] SAT_FIXED [6] = '{
      17'd131071, 17'd65535, 17'd1, 17'd65537, 17'd32768, 17'd65536
   };

   // Holds the saturation in force and the pixels still owed by the block.
   class saturate_checker;
      pixel_type owed_pixels[$];
      logic [SAT_BITS-1:0] saturation;
      int errors;

      function new();
         saturation = Q16_ONE;
         errors = 0;
      endfunction

      function void set_saturation(logic [SAT_BITS-1:0] value);
         saturation = value;
      endfunction

      function int pending();
         return owed_pixels.size();
      endfunction

      function pixel_type saturate_pixel(pixel_type px);
         logic [SAT_BITS-1:0] sat_eff;
         logic [COEF_BITS-1:0] inv, off_r, off_g, off_b, diag_r, diag_g, diag_b;
         logic [33:0] prod, sum;
         pixel_type res;
         // Anything above one is clipped to one, which gives the identity.
         sat_eff = (saturation > Q16_ONE) ? Q16_ONE : saturation;
         inv = Q16_ONE - sat_eff;
         prod = 34'(LUMA_R) * inv + 34'd32768;
         off_r = prod[32:16];
         prod = 34'(LUMA_G) * inv + 34'd32768;
         off_g = prod[32:16];
         prod = 34'(LUMA_B) * inv + 34'd32768;
         off_b = prod[32:16];
         diag_r = Q16_ONE - off_g - off_b;
         diag_g = Q16_ONE - off_r - off_b;
         diag_b = Q16_ONE - off_r - off_g;
         sum = diag_r * px.red + off_g * px.green + off_b * px.blue + 34'd32768;
         res.red = sum[CB+15:16];
         sum = off_r * px.red + diag_g * px.green + off_b * px.blue + 34'd32768;
         res.green = sum[CB+15:16];
         sum = off_r * px.red + off_g * px.green + diag_b * px.blue + 34'd32768;
         res.blue = sum[CB+15:16];
         res.alpha = px.alpha;
         return res;
      endfunction

      function void note_pixel(pixel_type px);
         owed_pixels.push_back(saturate_pixel(px));
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (owed_pixels.size() == 0) begin
            $error("rsp beat %h arrived with no pixel owed", got);
            errors++;
            return;
         end
         want = owed_pixels.pop_front();
         if (got.red !== want.red) begin
            $error("red_out: expected %0d, actual %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green_out: expected %0d, actual %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
            errors++;
         end
         if (got.alpha !== want.alpha) begin
            $error("alpha_out: expected %0d, actual %0d", want.alpha, got.alpha);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [SAT_BITS-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [4*CB-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [4*CB-1:0] rsp_tdata;

   saturate_checker sat_check = new();
   int cycle_count = 0;
   int hold_cycles = 0;
   bit sender_steady = 1'b0;
   bit ready_steady = 1'b0;

   color_saturate_matrix_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pause_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!ready_steady && $urandom_range(0, 3) == 0) hold_cycles <= pause_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sat_check.note_pixel(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sat_check.check_pixel(rsp_tdata);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("color_saturate_matrix_top_tb: errors");
         $finish;
      end
   end

   task automatic send_pixel(input pixel_type px);
      int gap;
      gap = (sender_steady || $urandom_range(0, 1) == 0) ? 0 : pause_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops sending and waits until the pipeline has returned every owed pixel.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (sat_check.pending() != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_saturation(input logic [SAT_BITS-1:0] value);
      drain_pipeline();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sat_check.set_saturation(value);
      sender_steady = ($urandom_range(0, 3) == 0);
      ready_steady = ($urandom_range(0, 3) == 0);
   endtask

   function automatic logic [CB-1:0] corner_value();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return 16'h0001;
         default: return 16'h8000;
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int shape;
      shape = $urandom_range(0, 9);
      px = pixel_type'({$urandom, $urandom});
      if (shape == 0) begin
         px.red = corner_value();
         px.green = corner_value();
         px.blue = corner_value();
      end else if (shape == 1) begin
         // Gray input stays gray at every saturation.
         px.green = px.red;
         px.blue = px.red;
      end
      return px;
   endfunction

   task automatic send_directed();
      for (int i = 0; i < 12; i++) send_pixel(pixel_type'(DIRECTED_PIXELS[i]));
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 199) == 0) drain_pipeline();
         send_pixel(random_pixel());
      end
   endtask

   initial begin
      logic [SAT_BITS-1:0] setting;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value first, then pure luma.
      send_directed();
      send_random(RANDOM_PER_PHASE);
      write_saturation('0);
      send_directed();
      send_random(RANDOM_PER_PHASE);

      for (int p = 0; p < 9; p++) begin
         setting = (p < 6) ? SAT_FIXED[p] : SAT_BITS'($urandom_range(0, 65536));
         write_saturation(setting);
         send_random(RANDOM_PER_PHASE);
      end

      drain_pipeline();
      if (sat_check.errors == 0 && sat_check.pending() == 0) begin
         $display("color_saturate_matrix_top_tb: clean");
      end else begin
         $display("color_saturate_matrix_top_tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/csm_pkg.sv
rtl/csm_coef.sv
rtl/csm_mac.sv
rtl/color_saturate_matrix_top.sv
bench/color_saturate_matrix_top_tb.sv
